// ----- rtl/mmp2_pkg.sv -----
// Shared types and constants for the 2x2 min/max pooling block.
`timescale 1ns / 1ps

package mmp2_pkg;

    // Height sample as carried on the ports and kept in the line store
    typedef logic signed [15:0] t_height;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_ROW_WIDTH   = 2'd0,
        CFG_ROW_COUNT   = 2'd1,
        CFG_SINGLE_MODE = 2'd2,
        CFG_UNUSED      = 2'd3
    } t_cfg_index;

    // Box start values and range limits
    localparam t_height BOX_START_MIN = 16'sd32000;
    localparam t_height BOX_START_MAX = -16'sd32000;
    localparam t_height LOW_LIMIT     = -16'sd500;
    localparam t_height HIGH_LIMIT    = 16'sd6000;

    // Position decode handed from the position tracker to the datapath
    typedef struct packed {
        logic first;    // first sample of its box: start from the box start values
        logic closing;  // closing sample of its box: a result is given
        logic row_end;  // box is the last one of its output row
    } t_pos_info;

endpackage

// ----- rtl/mmp2_position.sv -----
// Raster position tracker: column and row counters and box/group decode.
`timescale 1ns / 1ps

module mmp2_position #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_clear,
    input  logic                  i_advance,
    input  logic [12:0]           i_row_width,
    input  logic [15:0]           i_row_count,
    output logic [11:0]           o_box,
    output mmp2_pkg::t_pos_info   o_info
);

    logic [12:0] r_col, n_col;
    logic [15:0] r_row, n_row;

    logic [12:0] w_eff;
    logic [15:0] h_eff;
    logic [11:0] num_boxes;
    logic [11:0] col_half;
    logic        box_clamp;
    logic        last_box;
    logic [14:0] num_groups;
    logic [14:0] row_half;
    logic        group_clamp;
    logic        last_group;
    logic        col_wrap;
    logic        row_wrap;
    logic        first_col;
    logic        first_row;
    logic        closing_col;
    logic        closing_row;

    // Effective frame size: width clamped to [2, MAX_WIDTH], count to at least 2
    always_comb begin
        if (i_row_width < 13'd2) begin
            w_eff = 13'd2;
        end else if (int'(i_row_width) > MAX_WIDTH) begin
            w_eff = 13'(MAX_WIDTH);
        end else begin
            w_eff = i_row_width;
        end
        h_eff = (i_row_count < 16'd2) ? 16'd2 : i_row_count;
    end

    // Column decode: an odd last column folds into the box before it
    assign num_boxes   = w_eff[12:1];
    assign col_half    = r_col[12:1];
    assign box_clamp   = (col_half >= num_boxes);
    assign o_box       = box_clamp ? (num_boxes - 12'd1) : col_half;
    assign last_box    = box_clamp || (col_half == num_boxes - 12'd1);
    assign col_wrap    = (r_col == w_eff - 13'd1);
    assign first_col   = !r_col[0] && !box_clamp;
    assign closing_col = last_box ? col_wrap : r_col[0];

    // Row decode: an odd last row folds into the group before it
    assign num_groups  = h_eff[15:1];
    assign row_half    = r_row[15:1];
    assign group_clamp = (row_half >= num_groups);
    assign last_group  = group_clamp || (row_half == num_groups - 15'd1);
    assign row_wrap    = (r_row == h_eff - 16'd1);
    assign first_row   = !r_row[0] && !group_clamp;
    assign closing_row = last_group ? row_wrap : r_row[0];

    assign o_info.first   = first_col && first_row;
    assign o_info.closing = closing_col && closing_row;
    assign o_info.row_end = last_box;

    // Next position: wrap column at row end, row at frame end
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_advance) begin
            if (col_wrap) begin
                n_col = '0;
                n_row = row_wrap ? '0 : (r_row + 16'd1);
            end else begin
                n_col = r_col + 13'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

// ----- rtl/mmp2_line_store.sv -----
// Line store: one min/max entry per box of the current group row.
`timescale 1ns / 1ps

module mmp2_line_store #(
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = 11
) (
    input  logic                  i_clk,
    input  logic                  i_rd_en,
    input  logic [ADDR_W-1:0]     i_rd_addr,
    output mmp2_pkg::t_height     o_rd_min,
    output mmp2_pkg::t_height     o_rd_max,
    input  logic                  i_wr_en,
    input  logic [ADDR_W-1:0]     i_wr_addr,
    input  mmp2_pkg::t_height     i_wr_min,
    input  mmp2_pkg::t_height     i_wr_max
);

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rd_data;

    // One read and one write port; a read at the write address returns old data
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_min, i_wr_max};
        end
    end

    assign o_rd_min = r_rd_data[31:16];
    assign o_rd_max = r_rd_data[15:0];

endmodule

// ----- rtl/minmax_pool_2x2_downsample.sv -----
// Top level of the 2x2 min/max pooling downsampler.
`timescale 1ns / 1ps

// Height samples enter in raster order on the input channel (valid/ready);
// in single-sample mode i_low_height is used as both low and high. Each 2x2
// box (3 wide on an odd last column or row) gives one result on the output
// channel when its closing sample arrives: box minimum, box maximum, a flag
// for the last box of an output row and a sticky range error flag.
// Configuration is written through the cfg channel (index 0 row width,
// 1 row count, 2 single-sample mode); these writes restart the frame position.
// Throughput is one sample per cycle while no closing sample is held off.
// On the way to the output, the line store read is registered with the
// closing sample in stage 1, and the min/max update then loads the output
// register.
// Back-to-back samples of the same box are served by forwarding the last
// line store write. When the receiver stalls, the output register holds its
// result; samples that close no box still pass, and input is held off only
// when a closing sample waits behind a full output register.
// Reset clears the position counters, the error flag and all valid flags;
// the line store needs no clearing and is ready right after reset.
module minmax_pool_2x2_downsample #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration write channel
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data,
    // sample input channel
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic signed [15:0]  i_low_height,
    input  logic signed [15:0]  i_high_height,
    // result output channel
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic signed [15:0]  o_box_min,
    output logic signed [15:0]  o_box_max,
    output logic                o_row_end,
    output logic                o_range_error
);

    localparam int DEPTH  = MAX_WIDTH / 2;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Configuration registers
    logic [12:0] r_row_width;
    logic [15:0] r_row_count;
    logic        r_single_mode;
    logic        cfg_fire;

    // Input side
    logic                  in_fire;
    logic [11:0]           pos_box;
    mmp2_pkg::t_pos_info   pos_info;
    mmp2_pkg::t_height     in_high;

    // Stage 1: sample waiting for its line store read data
    logic                  r_s1_valid;
    mmp2_pkg::t_pos_info   r_s1_info;
    logic [ADDR_W-1:0]     r_s1_addr;
    mmp2_pkg::t_height     r_s1_low;
    mmp2_pkg::t_height     r_s1_high;
    logic                  r_s1_fwd;
    logic                  s1_fire;

    // Last line store write, for forwarding
    mmp2_pkg::t_height     r_lw_min;
    mmp2_pkg::t_height     r_lw_max;

    // Datapath
    mmp2_pkg::t_height     rd_min;
    mmp2_pkg::t_height     rd_max;
    mmp2_pkg::t_height     base_min;
    mmp2_pkg::t_height     base_max;
    mmp2_pkg::t_height     new_min;
    mmp2_pkg::t_height     new_max;
    logic                  r_err;
    logic                  err_next;

    // Output register
    logic                  r_out_valid;
    mmp2_pkg::t_height     r_out_min;
    mmp2_pkg::t_height     r_out_max;
    logic                  r_out_row_end;
    logic                  r_out_err;
    logic                  out_free;

    // Configuration writes; indexes past the register list are ignored
    assign o_cfg_ready = 1'b1;
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width   <= 13'd2;
            r_row_count   <= 16'd2;
            r_single_mode <= 1'b1;
        end else if (cfg_fire) begin
            unique case (mmp2_pkg::t_cfg_index'(i_cfg_index))
                mmp2_pkg::CFG_ROW_WIDTH:   r_row_width   <= i_cfg_data[12:0];
                mmp2_pkg::CFG_ROW_COUNT:   r_row_count   <= i_cfg_data;
                mmp2_pkg::CFG_SINGLE_MODE: r_single_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Handshake: stage 1 moves on unless a result is blocked by a full output
    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_fire    = r_s1_valid && (!r_s1_info.closing || out_free);
    assign o_in_ready = !r_s1_valid || s1_fire;
    assign in_fire    = i_in_valid && o_in_ready;

    mmp2_position #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_position (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (cfg_fire && (i_cfg_index != mmp2_pkg::CFG_UNUSED)),
        .i_advance   (in_fire),
        .i_row_width (r_row_width),
        .i_row_count (r_row_count),
        .o_box       (pos_box),
        .o_info      (pos_info)
    );

    assign in_high = r_single_mode ? i_low_height : i_high_height;

    // Stage 1 register; note when the previous sample writes our box this edge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_info <= pos_info;
            r_s1_addr <= ADDR_W'(pos_box);
            r_s1_low  <= i_low_height;
            r_s1_high <= in_high;
            r_s1_fwd  <= s1_fire && (r_s1_addr == ADDR_W'(pos_box));
        end
    end

    mmp2_line_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_rd_en   (in_fire),
        .i_rd_addr (ADDR_W'(pos_box)),
        .o_rd_min  (rd_min),
        .o_rd_max  (rd_max),
        .i_wr_en   (s1_fire),
        .i_wr_addr (r_s1_addr),
        .i_wr_min  (new_min),
        .i_wr_max  (new_max)
    );

    // Running min/max of the box: start values, forwarded write or stored entry
    always_comb begin
        if (r_s1_info.first) begin
            base_min = mmp2_pkg::BOX_START_MIN;
            base_max = mmp2_pkg::BOX_START_MAX;
        end else if (r_s1_fwd) begin
            base_min = r_lw_min;
            base_max = r_lw_max;
        end else begin
            base_min = rd_min;
            base_max = rd_max;
        end
        new_min  = (r_s1_low < base_min) ? r_s1_low : base_min;
        new_max  = (r_s1_high > base_max) ? r_s1_high : base_max;
        err_next = r_err || (r_s1_low <= mmp2_pkg::LOW_LIMIT)
                         || (r_s1_high >= mmp2_pkg::HIGH_LIMIT);
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_lw_min <= new_min;
            r_lw_max <= new_max;
        end
    end

    // Sticky range error, cleared only by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err <= 1'b0;
        end else if (s1_fire) begin
            r_err <= err_next;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && r_s1_info.closing) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && r_s1_info.closing) begin
            r_out_min     <= new_min;
            r_out_max     <= new_max;
            r_out_row_end <= r_s1_info.row_end;
            r_out_err     <= err_next;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_box_min     = r_out_min;
    assign o_box_max     = r_out_max;
    assign o_row_end     = r_out_row_end;
    assign o_range_error = r_out_err;

    // A closing sample leaving stage 1 always lands in the output register
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire && r_s1_info.closing |=> r_out_valid)
        else $error("closing sample did not produce a result");

    // The range error flag never clears outside reset
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |=> r_err)
        else $error("range error flag dropped");

    // An empty stage 1 always takes input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_valid |-> o_in_ready)
        else $error("input held off with stage 1 empty");

    // A result waiting on a stalled receiver keeps its error flag
    a_out_err_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=> r_out_valid && $stable(r_out_err))
        else $error("stalled result changed");

endmodule

// ----- tb/sv/minmax_pool_2x2_downsample_test.sv -----
// Self-checking testbench for the 2x2 min/max pooling downsampler.
`timescale 1ns / 1ps

// One finished box as seen on the result channel
typedef struct packed {
    mmp2_pkg::t_height box_min;
    mmp2_pkg::t_height box_max;
    logic              row_end;
    logic              range_error;
} t_box_result;

// Tracks raster position and line store, predicts boxes and checks them
class box_scoreboard;
    localparam int MAX_COLS = 4096;

    logic [12:0]        row_width;
    logic [15:0]        row_count;
    logic               single_mode;
    mmp2_pkg::t_height  min_line[MAX_COLS / 2];
    mmp2_pkg::t_height  max_line[MAX_COLS / 2];
    int unsigned        col;
    int unsigned        row;
    logic               error_seen;
    t_box_result        expected_boxes[$];
    int unsigned        fault_count;

    function new();
        row_width   = 13'd2;
        row_count   = 16'd2;
        single_mode = 1'b1;
        col         = 0;
        row         = 0;
        error_seen  = 1'b0;
        fault_count = 0;
    endfunction

    function int unsigned eff_width();
        if (row_width < 2) return 2;
        if (row_width > MAX_COLS) return MAX_COLS;
        return row_width;
    endfunction

    function int unsigned eff_count();
        return (row_count < 2) ? 2 : row_count;
    endfunction

    function longint unsigned frame_samples();
        return longint'(eff_width()) * eff_count();
    endfunction

    // Pairs of positions form a group; an odd tail joins the last group
    function int unsigned group_index(int unsigned pos, int unsigned len);
        int unsigned g;
        g = pos / 2;
        return (g >= len / 2) ? len / 2 - 1 : g;
    endfunction

    function int unsigned group_end(int unsigned g, int unsigned len);
        return (g == len / 2 - 1) ? len - 1 : 2 * g + 1;
    endfunction

    function int unsigned pending();
        return expected_boxes.size();
    endfunction

    // Register transfer: any known index restarts the frame position
    function void apply_write(mmp2_pkg::t_cfg_index idx, logic [15:0] data);
        case (idx)
            mmp2_pkg::CFG_ROW_WIDTH:   row_width = data[12:0];
            mmp2_pkg::CFG_ROW_COUNT:   row_count = data;
            mmp2_pkg::CFG_SINGLE_MODE: single_mode = data[0];
            default:                   return;
        endcase
        col = 0;
        row = 0;
    endfunction

    // Fold one accepted sample into its box; queue the box if it closes here
    function void note_sample(mmp2_pkg::t_height lo_in, mmp2_pkg::t_height hi_in);
        int unsigned w, h, c, r, box, grp;
        int          lo, hi, mn, mx;
        t_box_result res;
        w   = eff_width();
        h   = eff_count();
        c   = (col < w) ? col : 0;
        r   = (row < h) ? row : 0;
        box = group_index(c, w);
        grp = group_index(r, h);
        lo  = lo_in;
        hi  = single_mode ? lo : int'(hi_in);

        if (lo <= mmp2_pkg::LOW_LIMIT || hi >= mmp2_pkg::HIGH_LIMIT) error_seen = 1'b1;

        if (r == 2 * grp && c == 2 * box) begin
            mn = mmp2_pkg::BOX_START_MIN;
            mx = mmp2_pkg::BOX_START_MAX;
        end else begin
            mn = min_line[box];
            mx = max_line[box];
        end
        if (lo < mn) mn = lo;
        if (hi > mx) mx = hi;
        min_line[box] = mmp2_pkg::t_height'(mn);
        max_line[box] = mmp2_pkg::t_height'(mx);

        if (r == group_end(grp, h) && c == group_end(box, w)) begin
            res.box_min     = mmp2_pkg::t_height'(mn);
            res.box_max     = mmp2_pkg::t_height'(mx);
            res.row_end     = (box == w / 2 - 1);
            res.range_error = error_seen;
            expected_boxes.push_back(res);
        end

        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        col = c;
        row = r;
    endfunction

    function void report(string msg);
        fault_count++;
        if (fault_count <= 10) $display("MISMATCH: %s", msg);
    endfunction

    function void check_box(t_box_result got);
        t_box_result want;
        if (expected_boxes.size() == 0) begin
            report($sformatf("unexpected box min %0d max %0d row_end %0b range_error %0b",
                             got.box_min, got.box_max, got.row_end, got.range_error));
            return;
        end
        want = expected_boxes.pop_front();
        if (got.box_min !== want.box_min || got.box_max !== want.box_max ||
            got.row_end !== want.row_end || got.range_error !== want.range_error) begin
            report($sformatf({"expected min %0d max %0d row_end %0b range_error %0b, ",
                              "got min %0d max %0d row_end %0b range_error %0b"},
                             want.box_min, want.box_max, want.row_end, want.range_error,
                             got.box_min, got.box_max, got.row_end, got.range_error));
        end
    endfunction

    function void flush_leftover();
        if (expected_boxes.size() != 0)
            report($sformatf("%0d expected boxes never arrived", expected_boxes.size()));
    endfunction
endclass

module minmax_pool_2x2_downsample_test;

    localparam int TOTAL_ITEMS  = 1150;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int PIPE_SETTLE  = 8;
    localparam int STALL_CYCLES = 400;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [1:0]          i_cfg_index;
    logic [15:0]         i_cfg_data;
    logic                i_in_valid;
    logic                o_in_ready;
    logic signed [15:0]  i_low_height;
    logic signed [15:0]  i_high_height;
    logic                o_out_valid;
    logic                i_out_ready;
    logic signed [15:0]  o_box_min;
    logic signed [15:0]  o_box_max;
    logic                o_row_end;
    logic                o_range_error;

    box_scoreboard pooler;
    int unsigned   items_done    = 0;
    int unsigned   send_idle_pct = 32;
    int unsigned   recv_idle_pct = 53;
    int unsigned   recv_hold     = 0;

    minmax_pool_2x2_downsample u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_low_height  (i_low_height),
        .i_high_height (i_high_height),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_box_min     (o_box_min),
        .o_box_max     (o_box_max),
        .o_row_end     (o_row_end),
        .o_range_error (o_range_error)
    );

    // 100 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Result receiver: random back-pressure, plus a long hold-off on request
    initial begin : receiver
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (recv_hold > 0) begin
                i_out_ready = 1'b0;
                recv_hold--;
            end else begin
                i_out_ready = ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Check every result transfer against the oldest predicted box
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            pooler.check_box(t_box_result'{o_box_min, o_box_max, o_row_end, o_range_error});
    end

    // Biased height: full range, box start corners, range limits, typical terrain
    function automatic mmp2_pkg::t_height pick_height();
        case ($urandom_range(5))
            0, 1:    return mmp2_pkg::t_height'($urandom);
            2:       return mmp2_pkg::t_height'(32000 + int'($urandom_range(767)));
            3:       return mmp2_pkg::t_height'(-32000 - int'($urandom_range(768)));
            4:       return $urandom_range(1)
                         ? mmp2_pkg::t_height'(mmp2_pkg::LOW_LIMIT
                                               + int'($urandom_range(2)) - 1)
                         : mmp2_pkg::t_height'(mmp2_pkg::HIGH_LIMIT
                                               + int'($urandom_range(2)) - 1);
            default: return mmp2_pkg::t_height'(int'($urandom_range(6200)) - 300);
        endcase
    endfunction

    // One sample transfer, with random idle cycles ahead of it
    task automatic send_sample(input mmp2_pkg::t_height lo, input mmp2_pkg::t_height hi);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        if (items_done < TOTAL_ITEMS / 3) begin
            send_idle_pct = 32;
            recv_idle_pct = 53;
        end else if (items_done < 2 * TOTAL_ITEMS / 3) begin
            send_idle_pct = 53;
            recv_idle_pct = 32;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    = 1'b1;
        i_low_height  = lo;
        i_high_height = hi;
        do @(posedge i_clk); while (!o_in_ready);
        pooler.note_sample(lo, hi);
        items_done++;
    endtask

    // One register transfer; valid is dropped by the next sample or drain
    task automatic write_reg(input mmp2_pkg::t_cfg_index idx, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        pooler.apply_write(idx, data);
    endtask

    // Hold the input until every predicted box is out, then let the pipe settle
    task automatic wait_drained();
        int unsigned guard;
        @(negedge i_clk);
        i_in_valid  = 1'b0;
        i_cfg_valid = 1'b0;
        for (guard = 0; pooler.pending() != 0 && guard < DRAIN_LIMIT; guard++)
            @(posedge i_clk);
        repeat (PIPE_SETTLE) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int unsigned        phase, n, k, first, sel, pause_at, i;
        logic [15:0]        w_data, h_data, mode_data;
        longint unsigned    frame;
        mmp2_pkg::t_height  lo, hi, tmp;

        pooler        = new();
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = mmp2_pkg::CFG_ROW_WIDTH;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_low_height  = '0;
        i_high_height = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset setting, single-sample mode: in-range box, then frames that
        // clamp at the box start values; the range flag goes sticky
        send_sample(16'sd5999, pick_height());
        send_sample(-16'sd499, pick_height());
        send_sample(16'sd0, pick_height());
        send_sample(16'sd100, pick_height());
        send_sample(16'sh7FFF, pick_height());
        send_sample(16'sd32001, pick_height());
        send_sample(16'sd32500, pick_height());
        send_sample(16'sh7FFF, pick_height());
        send_sample(16'sh8000, pick_height());
        send_sample(-16'sd32001, pick_height());
        send_sample(-16'sd32500, pick_height());
        send_sample(16'sh8000, pick_height());

        // Low/high pairs on a 3x3 frame: one 3-wide box in both directions.
        // A write to the unused index in mid-box must not restart the position.
        wait_drained();
        write_reg(mmp2_pkg::CFG_SINGLE_MODE, 16'hFFFE);
        write_reg(mmp2_pkg::CFG_ROW_WIDTH, 16'd3);
        write_reg(mmp2_pkg::CFG_ROW_COUNT, 16'd3);
        send_sample(-16'sd500, 16'sd6000);
        send_sample(16'sh8000, 16'sh7FFF);
        send_sample(16'sh7FFF, 16'sh8000);
        send_sample(16'sd0, 16'sd0);
        wait_drained();
        write_reg(mmp2_pkg::CFG_UNUSED, 16'hFFFF);
        send_sample(-16'sd1, -16'sd1);
        send_sample(16'sd100, 16'sd200);
        send_sample(16'sd6001, -16'sd501);
        send_sample(16'sd7, 16'sd7);
        send_sample(-16'sd32000, 16'sd32000);

        // Random phases, each with its own frame setting
        phase = 0;
        while (items_done < TOTAL_ITEMS) begin
            case (phase)
                0: begin       // width beyond maximum, largest count
                    w_data = 16'hFFFF;
                    h_data = 16'hFFFF;
                end
                1: begin       // both below minimum
                    w_data = 16'h0000;
                    h_data = 16'h0000;
                end
                2: begin       // exactly the maximum width
                    w_data = 16'd4096;
                    h_data = 16'd1;
                end
                3: begin       // narrow frame for the long receiver hold-off
                    w_data = 16'd2;
                    h_data = 16'd20;
                end
                default: begin
                    sel = $urandom_range(19);
                    if (sel == 0)      w_data = 16'($urandom_range(1));
                    else if (sel == 1) w_data = 16'($urandom_range(4097, 8191));
                    else if (sel == 2) w_data = 16'($urandom_range(13, 64));
                    else               w_data = 16'($urandom_range(2, 12));
                    w_data[15:13] = 3'($urandom);
                    sel = $urandom_range(19);
                    if (sel == 0)      h_data = 16'($urandom_range(1));
                    else if (sel == 1) h_data = 16'($urandom_range(60000, 65535));
                    else               h_data = 16'($urandom_range(2, 7));
                end
            endcase
            mode_data = {15'($urandom), 1'($urandom)};

            // Registers only change with the block idle, in random order
            wait_drained();
            first = $urandom_range(2);
            for (k = 0; k < 3; k++) begin
                case ((first + k) % 3)
                    0:       write_reg(mmp2_pkg::CFG_ROW_WIDTH, w_data);
                    1:       write_reg(mmp2_pkg::CFG_ROW_COUNT, h_data);
                    default: write_reg(mmp2_pkg::CFG_SINGLE_MODE, mode_data);
                endcase
            end
            if ($urandom_range(3) == 0) write_reg(mmp2_pkg::CFG_UNUSED, 16'($urandom));

            // Mostly whole frames; sometimes cut short by the next setting
            frame = pooler.frame_samples();
            if (frame <= 200) n = int'(frame) * $urandom_range(1, 2);
            else              n = $urandom_range(20, 40);
            if (phase != 3 && $urandom_range(4) == 0) n = $urandom_range(1, n);
            if (n > TOTAL_ITEMS - items_done) n = TOTAL_ITEMS - items_done;
            pause_at = (phase == 4 || $urandom_range(3) == 0) ? n / 2 : n;
            if (phase == 3) recv_hold = STALL_CYCLES;

            for (i = 0; i < n; i++) begin
                if (i == pause_at) wait_drained();
                lo = pick_height();
                hi = pick_height();
                if (lo > hi && $urandom_range(9) < 7) begin
                    tmp = lo;
                    lo  = hi;
                    hi  = tmp;
                end
                send_sample(lo, hi);
            end
            phase++;
        end

        wait_drained();
        pooler.flush_leftover();
        if (pooler.fault_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/mmp2_pkg.sv
rtl/mmp2_position.sv
rtl/mmp2_line_store.sv
rtl/minmax_pool_2x2_downsample.sv
tb/sv/minmax_pool_2x2_downsample_test.sv
